/* hw/rtl/pidl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // operation codes carried on req_operation
   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_FIND       = 3'd6,
      OP_MODIFY     = 3'd7
   } op_type;

   // status codes carried on rsp_status
   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_RANGE = 3'd3,
      ST_MISS  = 3'd4
   } status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_WRITE  = 2'd1,  // load value at pos
      ACT_INSERT = 2'd2,  // load value at pos, cells above take lower neighbor
      ACT_REMOVE = 2'd3   // cells at and above pos take upper neighbor
   } action_type;

endpackage
`default_nettype wire

/* hw/rtl/pidl_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds an entry, shifts with its neighbors, compares a key.
// ----------------------------------------------------------------------------
module pidl_cell #(
   parameter int INDEX      = 0,
   parameter int IDX_W      = 4,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire pidl_pkg::action_type   action,
   input  wire logic [IDX_W-1:0]       pos,
   input  wire logic [DATA_WIDTH-1:0]  value,
   input  wire logic [DATA_WIDTH-1:0]  lower_data,
   input  wire logic [DATA_WIDTH-1:0]  upper_data,
   output logic [DATA_WIDTH-1:0]       data,
   output logic                        match
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (action)
         pidl_pkg::ACT_WRITE: begin
            if (MY_IDX == pos) data_in = value;
         end
         pidl_pkg::ACT_INSERT: begin
            if (MY_IDX == pos)     data_in = value;
            else if (MY_IDX > pos) data_in = lower_data;
         end
         pidl_pkg::ACT_REMOVE: begin
            if (MY_IDX >= pos) data_in = upper_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == value);

endmodule
`default_nettype wire

/* hw/rtl/pidl_first_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_first_match
// Priority encoder: lowest set bit of the cell match vector.
// ----------------------------------------------------------------------------
module pidl_first_match #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  wire logic [DEPTH-1:0] match_vec,
   output logic                  hit,
   output logic [IDX_W-1:0]      index
);

   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit   = 1'b1;
            index = IDX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/positional_insert_delete_list.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of up to DEPTH values held in a chain of register cells.
// ----------------------------------------------------------------------------
// Output: a result appears on rsp_ in the cycle after its request is taken.
// Throughput: one request word per cycle while the result register is empty or
//   being drained by rsp_ready; every operation, including the shifts of
//   insert/erase and the find compare, finishes as all cells update together.
// Reset: clears the element count and the result valid. Cell contents are
//   not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
   parameter int DEPTH      = pidl_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEFAULT,
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request word
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [2:0]                   req_operation,
   input  wire logic [IDX_W-1:0]             req_position,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   // result word
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_found,
   output logic [IDX_W-1:0]                  rsp_match_index,
   output logic [CNT_W-1:0]                  rsp_count
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // ---- state ------------------------------------------------------------
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff;
   logic                  rsp_found_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   // ---- handshake --------------------------------------------------------
   // The result register frees up in the same cycle it is drained, so a new
   // request can be taken every cycle as long as the consumer keeps up.
   logic accept;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // ---- cell chain -------------------------------------------------------
   // Each cell sees its lower and upper neighbor; insert pulls data up the
   // chain, erase pulls it down. All cells move in the same edge.
   pidl_pkg::action_type  action;
   logic [IDX_W-1:0]      act_pos;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_eq;
   logic [DEPTH-1:0]      occupied;
   logic [DATA_WIDTH-1:0] value_bits;

   assign value_bits = req_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_d;
      logic [DATA_WIDTH-1:0] upper_d;

      if (i == 0) begin : g_lo_end
         assign lower_d = value_bits;
      end else begin : g_lo
         assign lower_d = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_hi_end
         assign upper_d = cell_data[i];
      end else begin : g_hi
         assign upper_d = cell_data[i+1];
      end

      pidl_cell #(
         .INDEX      (i),
         .IDX_W      (IDX_W),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .enable     (accept),
         .action     (action),
         .pos        (act_pos),
         .value      (value_bits),
         .lower_data (lower_d),
         .upper_data (upper_d),
         .data       (cell_data[i]),
         .match      (cell_eq[i])
      );

      // only slots below the count take part in a search
      assign occupied[i] = (CNT_W'(i) < count_ff);
   end

   // ---- find -------------------------------------------------------------
   logic             find_hit;
   logic [IDX_W-1:0] find_index;

   pidl_first_match #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_first_match (
      .match_vec (cell_eq & occupied),
      .hit       (find_hit),
      .index     (find_index)
   );

   // ---- operation decode -------------------------------------------------
   // Push back is an insert at the current count; push front and pop front
   // are insert/erase at slot zero. Pop back only drops the count.
   pidl_pkg::status_type status_c;
   logic                 found_c;
   logic [IDX_W-1:0]     index_c;
   logic [CNT_W-1:0]     pos_ext;
   logic                 is_full;
   logic                 is_empty;

   assign pos_ext  = CNT_W'(req_position);
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      status_c = pidl_pkg::ST_OK;
      found_c  = 1'b0;
      index_c  = '0;
      action   = pidl_pkg::ACT_NONE;
      act_pos  = req_position;
      count_in = count_ff;
      unique case (pidl_pkg::op_type'(req_operation))
         pidl_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               status_c = pidl_pkg::ST_FULL;
            end else begin
               action   = pidl_pkg::ACT_INSERT;
               act_pos  = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         pidl_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               status_c = pidl_pkg::ST_FULL;
            end else begin
               action   = pidl_pkg::ACT_INSERT;
               act_pos  = '0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         pidl_pkg::OP_POP_BACK: begin
            if (is_empty) status_c = pidl_pkg::ST_EMPTY;
            else          count_in = count_ff - CNT_W'(1);
         end
         pidl_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status_c = pidl_pkg::ST_EMPTY;
            end else begin
               action   = pidl_pkg::ACT_REMOVE;
               act_pos  = '0;
               count_in = count_ff - CNT_W'(1);
            end
         end
         pidl_pkg::OP_INSERT: begin
            // appending at position == count is legal
            if (pos_ext > count_ff) begin
               status_c = pidl_pkg::ST_RANGE;
            end else if (is_full) begin
               status_c = pidl_pkg::ST_FULL;
            end else begin
               action   = pidl_pkg::ACT_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         pidl_pkg::OP_ERASE: begin
            if (pos_ext >= count_ff) begin
               status_c = pidl_pkg::ST_RANGE;
            end else begin
               action   = pidl_pkg::ACT_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         pidl_pkg::OP_FIND: begin
            if (find_hit) begin
               found_c = 1'b1;
               index_c = find_index;
            end else begin
               status_c = pidl_pkg::ST_MISS;
            end
         end
         pidl_pkg::OP_MODIFY: begin
            if (pos_ext >= count_ff) status_c = pidl_pkg::ST_RANGE;
            else                     action   = pidl_pkg::ACT_WRITE;
         end
      endcase
   end

   // ---- registers --------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (accept)    rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // result payload, loaded with the request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_c;
         rsp_found_ff  <= found_c;
         rsp_index_ff  <= index_c;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_count       = rsp_count_ff;

endmodule
`default_nettype wire
